// ----- rtl/tfm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfm_pkg
// Shared constants and types of the topic filter matcher: word kinds,
// wildcard and separator characters, and the result word.
// ----------------------------------------------------------------------------
package tfm_pkg;

   localparam int MAX_FILTER_BYTES_DEFAULT = 256;

   // word kinds on the request channel
   localparam logic REQ_FILTER = 1'b0;
   localparam logic REQ_TOPIC  = 1'b1;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;

   typedef struct packed {
      logic matched;
      logic filter_overflow;
   } result_type;

endpackage

// ----- rtl/tfm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfm_ram
// Generic RAM: one write port, two registered read ports, write-first on an
// address clash.
// ----------------------------------------------------------------------------
module tfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr_a)) begin
         rd_data_a_ff <= wr_data;
      end else begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
      end
      if (wr_en && (wr_addr == rd_addr_b)) begin
         rd_data_b_ff <= wr_data;
      end else begin
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- rtl/tfm_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfm_match
// Filter load and topic compare. Keeps the filter length, the compare
// pointer and mode, and the last three filter characters for the end check.
// The store is read at the pointer and the pointer plus one.
// ----------------------------------------------------------------------------
module tfm_match #(
   parameter int MAX_FILTER_BYTES = tfm_pkg::MAX_FILTER_BYTES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_accept,
   input  logic                                req_type,
   input  logic [7:0]                          data_byte,
   input  logic                                last,
   output logic                                wr_en,
   output logic [$clog2(MAX_FILTER_BYTES)-1:0] wr_addr,
   output logic [7:0]                          wr_data,
   output logic [$clog2(MAX_FILTER_BYTES)-1:0] rd_addr_a,
   input  logic [7:0]                          rd_data_a,
   output logic [$clog2(MAX_FILTER_BYTES)-1:0] rd_addr_b,
   input  logic [7:0]                          rd_data_b,
   output logic                                res_valid,
   output tfm_pkg::result_type                 res
);

   import tfm_pkg::*;

   localparam int ADDR_W = $clog2(MAX_FILTER_BYTES);
   localparam int LEN_W  = $clog2(MAX_FILTER_BYTES + 1);
   localparam int XW     = LEN_W + 2;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FILTER_BYTES);

   typedef enum logic [1:0] {
      MODE_COMPARE    = 2'd0,
      MODE_SKIP_LEVEL = 2'd1,
      MODE_SKIP_ALL   = 2'd2
   } mode_type;

   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] ptr_ff, ptr_in;
   logic             filter_valid_ff, filter_valid_in;
   mode_type         mode_ff, mode_in;
   logic             failed_ff, failed_in;
   logic             topic_first_ff, topic_first_in;
   logic             overflow_ff, overflow_in;
   logic             prev_slash_ff, prev_slash_in;
   logic             dollar_ff, dollar_in;
   logic [7:0]       tail0_ff, tail0_in;
   logic [7:0]       tail1_ff, tail1_in;
   logic [7:0]       tail2_ff, tail2_in;

   always_comb begin
      logic             first;
      logic [LEN_W-1:0] len_eff;
      logic [LEN_W-1:0] f_ptr;
      mode_type         f_mode;
      logic             f_failed;
      logic             f_prev;
      logic             do_cmp;
      logic             lvl;
      logic             fin;
      logic [XW-1:0]    px;
      logic [XW-1:0]    lx;

      len_in          = len_ff;
      ptr_in          = ptr_ff;
      filter_valid_in = filter_valid_ff;
      mode_in         = mode_ff;
      failed_in       = failed_ff;
      topic_first_in  = topic_first_ff;
      overflow_in     = overflow_ff;
      prev_slash_in   = prev_slash_ff;
      dollar_in       = dollar_ff;
      tail0_in        = tail0_ff;
      tail1_in        = tail1_ff;
      tail2_in        = tail2_ff;
      wr_en           = 1'b0;
      wr_addr         = '0;
      wr_data         = data_byte;
      res_valid       = 1'b0;
      res             = '0;
      first           = filter_valid_ff;
      len_eff         = first ? '0 : len_ff;
      f_ptr           = ptr_ff;
      f_mode          = mode_ff;
      f_failed        = failed_ff;
      f_prev          = prev_slash_ff;
      do_cmp          = 1'b0;
      lvl             = 1'b0;
      fin             = 1'b0;
      lx              = {2'b00, len_ff};
      px              = {2'b00, ptr_ff};

      if (req_accept && (req_type == REQ_FILTER)) begin
         // filter word: append to the filter, or start a new filter after a complete one
         topic_first_in  = 1'b1;
         mode_in         = MODE_COMPARE;
         failed_in       = 1'b0;
         ptr_in          = '0;
         prev_slash_in   = 1'b0;
         len_in          = len_eff;
         overflow_in     = first ? 1'b0 : overflow_ff;
         filter_valid_in = last;
         if (!(first && last && (data_byte == CHAR_NUL))) begin
            if (len_eff < LEN_MAX) begin
               wr_en    = 1'b1;
               wr_addr  = len_eff[ADDR_W-1:0];
               len_in   = len_eff + LEN_W'(1);
               tail2_in = tail1_ff;
               tail1_in = tail0_ff;
               tail0_in = data_byte;
               if (len_eff == '0) begin
                  dollar_in = (data_byte == CHAR_DOLLAR);
               end
            end else begin
               overflow_in = 1'b1;
            end
         end
      end else if (req_accept) begin
         // topic word
         filter_valid_in = 1'b1;
         if (topic_first_ff) begin
            topic_first_in = 1'b0;
            if (((data_byte == CHAR_NUL) && last) || (len_ff == '0) ||
                (dollar_ff != (data_byte == CHAR_DOLLAR))) begin
               f_failed = 1'b1;
            end
         end
         if (!f_failed) begin
            if ((data_byte == CHAR_PLUS) || (data_byte == CHAR_HASH)) begin
               f_failed = 1'b1;
            end else begin
               case (f_mode)
                  MODE_COMPARE: begin
                     do_cmp = 1'b1;
                  end
                  MODE_SKIP_LEVEL: begin
                     if (data_byte == CHAR_SLASH) begin
                        f_mode = MODE_COMPARE;
                        do_cmp = 1'b1;
                     end
                  end
                  MODE_SKIP_ALL: begin
                  end
                  default: begin
                     f_failed = 1'b1;
                  end
               endcase
            end
         end
         if (do_cmp) begin
            lvl = (ptr_ff == '0) || prev_slash_ff;
            if (ptr_ff >= len_ff) begin
               f_failed = 1'b1;
            end else if (rd_data_a == data_byte) begin
               f_ptr  = ptr_ff + LEN_W'(1);
               f_prev = (data_byte == CHAR_SLASH);
            end else if (rd_data_a == CHAR_PLUS) begin
               if (!lvl || !(((px + XW'(1)) == lx) || (rd_data_b == CHAR_SLASH))) begin
                  f_failed = 1'b1;
               end else if (data_byte == CHAR_SLASH) begin
                  if ((px + XW'(1)) >= lx) begin
                     f_failed = 1'b1;
                  end else begin
                     f_ptr  = ptr_ff + LEN_W'(2);
                     f_prev = 1'b1;
                  end
               end else begin
                  f_mode = MODE_SKIP_LEVEL;
                  f_ptr  = ptr_ff + LEN_W'(1);
                  f_prev = 1'b0;
               end
            end else if (rd_data_a == CHAR_HASH) begin
               if (!lvl || ((px + XW'(1)) != lx)) begin
                  f_failed = 1'b1;
               end else begin
                  f_mode = MODE_SKIP_ALL;
               end
            end else begin
               f_failed = 1'b1;
            end
         end

         // end of topic check on the state after this word
         px  = {2'b00, f_ptr};
         lvl = (f_ptr == '0) || f_prev;
         if (f_failed) begin
            fin = 1'b0;
         end else if (f_mode == MODE_SKIP_ALL) begin
            fin = 1'b1;
         end else if ((f_mode != MODE_COMPARE) && (f_mode != MODE_SKIP_LEVEL)) begin
            fin = 1'b0;
         end else if (f_ptr >= len_ff) begin
            fin = 1'b1;
         end else if ((px + XW'(1)) == lx) begin
            fin = lvl && ((tail0_ff == CHAR_PLUS) || (tail0_ff == CHAR_HASH));
         end else if ((px + XW'(2)) == lx) begin
            fin = (tail1_ff == CHAR_SLASH) && (tail0_ff == CHAR_HASH);
         end else if ((px + XW'(3)) == lx) begin
            fin = lvl && (tail2_ff == CHAR_PLUS) && (tail1_ff == CHAR_SLASH) &&
                  (tail0_ff == CHAR_HASH);
         end else begin
            fin = 1'b0;
         end

         if (last) begin
            res_valid           = 1'b1;
            res.matched         = fin;
            res.filter_overflow = overflow_ff;
            topic_first_in      = 1'b1;
            ptr_in              = '0;
            mode_in             = MODE_COMPARE;
            failed_in           = 1'b0;
            prev_slash_in       = 1'b0;
         end else begin
            ptr_in        = f_ptr;
            mode_in       = f_mode;
            failed_in     = f_failed;
            prev_slash_in = f_prev;
         end
      end
   end

   // store is always read at the next pointer and the one after it
   assign rd_addr_a = ptr_in[ADDR_W-1:0];
   assign rd_addr_b = ADDR_W'(ptr_in + LEN_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff          <= '0;
         ptr_ff          <= '0;
         filter_valid_ff <= 1'b1;
         mode_ff         <= MODE_COMPARE;
         failed_ff       <= 1'b0;
         topic_first_ff  <= 1'b1;
         overflow_ff     <= 1'b0;
         prev_slash_ff   <= 1'b0;
      end else begin
         len_ff          <= len_in;
         ptr_ff          <= ptr_in;
         filter_valid_ff <= filter_valid_in;
         mode_ff         <= mode_in;
         failed_ff       <= failed_in;
         topic_first_ff  <= topic_first_in;
         overflow_ff     <= overflow_in;
         prev_slash_ff   <= prev_slash_in;
      end
      dollar_ff <= dollar_in;
      tail0_ff  <= tail0_in;
      tail1_ff  <= tail1_in;
      tail2_ff  <= tail2_in;
   end

   a_topic_start_clean: assert property (@(posedge clock) disable iff (reset)
      topic_first_ff |-> ((ptr_ff == '0) && (mode_ff == MODE_COMPARE) && !failed_ff))
      else $error("topic start state not clean");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (len_ff <= LEN_MAX) && (ptr_ff <= len_ff))
      else $error("filter length or pointer out of range");

   a_filter_end: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_type == REQ_FILTER) && last) |=> (filter_valid_ff && topic_first_ff))
      else $error("filter not closed after its last word");

endmodule

// ----- rtl/tfm_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfm_out_buf
// Two-entry result buffer: output register plus skid register, so the
// request side keeps flowing while a result waits.
// ----------------------------------------------------------------------------
module tfm_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  tfm_pkg::result_type in_data,
   output logic                in_stall,
   output logic                out_valid,
   output tfm_pkg::result_type out_data,
   input  logic                out_stall
);

   import tfm_pkg::*;

   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff, skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || !out_stall) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = in_valid;
            skid_data_in  = in_data;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held with empty output register");

   a_skid_catches: assert property (@(posedge clock) disable iff (reset)
      (in_valid && out_valid_ff && out_stall) |=> skid_valid_ff)
      else $error("result word lost while output stalled");

endmodule

// ----- rtl/topic_filter_matcher_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topic_filter_matcher_core
// Subscription filter matcher: stores a filter word by word, then compares
// a streamed topic against it and reports a match on the topic's last word.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_req_type, req_data_byte, req_last
//   rsp     | out       | rsp_valid / rsp_stall | rsp_matched, rsp_filter_overflow
//
// one request word per cycle while req_stall is low, one read of the filter
// RAM (two ports) per word; results are registered in the output buffer
// synchronous reset clears control state; the filter RAM is not cleared
// a two-word output buffer takes results while rsp is stalled; req_stall
// rises only when both buffer entries are full
// ----------------------------------------------------------------------------
module topic_filter_matcher_core #(
   parameter int MAX_FILTER_BYTES = tfm_pkg::MAX_FILTER_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_req_type,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_matched,
   output logic       rsp_filter_overflow
);

   import tfm_pkg::*;

   localparam int ADDR_W = $clog2(MAX_FILTER_BYTES);

   logic              req_accept;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [7:0]        rd_data_a;
   logic [ADDR_W-1:0] rd_addr_b;
   logic [7:0]        rd_data_b;
   logic              res_valid;
   result_type        res;
   result_type        rsp_data;

   assign req_accept = req_valid && !req_stall;

   tfm_ram #(
      .WIDTH (8),
      .DEPTH (MAX_FILTER_BYTES)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   tfm_match #(
      .MAX_FILTER_BYTES (MAX_FILTER_BYTES)
   ) u_match (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_type   (req_req_type),
      .data_byte  (req_data_byte),
      .last       (req_last),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr_a  (rd_addr_a),
      .rd_data_a  (rd_data_a),
      .rd_addr_b  (rd_addr_b),
      .rd_data_b  (rd_data_b),
      .res_valid  (res_valid),
      .res        (res)
   );

   tfm_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

   assign rsp_matched         = rsp_data.matched;
   assign rsp_filter_overflow = rsp_data.filter_overflow;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the topic filter matcher core. Filters and topics
// are streamed in word by word, and each topic's verdict is checked against
// a behavioural model kept in step with the accepted request words, or
// against a value pinned in the table. A short table of hand-picked words
// runs first. Random filter/topic pairs, noise and broken sequences follow
// under four patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
   import tfm_pkg::*;

   localparam int MAX_BYTES    = MAX_FILTER_BYTES_DEFAULT;
   localparam int RANDOM_WORDS = 1950;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;

   typedef logic [7:0] bytes_type [$];
   typedef enum logic [1:0] {MODE_LITERAL, MODE_SKIP_LEVEL, MODE_SKIP_REST} scan_mode_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic       last;
      logic       pinned;
      logic       pin_matched;
      logic       pin_overflow;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_req_type;
   logic [7:0] req_data_byte;
   logic       req_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_matched;
   logic       rsp_filter_overflow;

   // model state
   logic [7:0]    flt_mem [MAX_BYTES];
   logic [8:0]    flt_len;
   logic [8:0]    flt_ptr;
   bit            flt_done;
   scan_mode_type scan_mode;
   bit            miss;
   bit            topic_head;
   bit            ovf;

   result_type   verdicts_due [$];
   stim_row_type dir_rows [25];

   int  send_idle_pct;
   int  rsp_stall_pct;
   int  words_sent;
   int  verdicts_checked;
   int  overflow_verdicts;
   int  errors;
   int  cycle_count;
   bit  pin_on;
   bit  pin_matched;
   bit  pin_overflow;

   topic_filter_matcher_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_req_type        (req_req_type),
      .req_data_byte       (req_data_byte),
      .req_last            (req_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_matched         (rsp_matched),
      .rsp_filter_overflow (rsp_filter_overflow)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit stored_is(input int p, input logic [7:0] ch);
      return p < flt_len && flt_mem[p[7:0]] == ch;
   endfunction

   function automatic bit level_head(input int p);
      return p == 0 || stored_is(p - 1, CHAR_SLASH);
   endfunction

   function automatic void scan_literal(input logic [7:0] c);
      int         p;
      logic [7:0] s;
      p = int'(flt_ptr);
      if (p >= flt_len) begin
         miss = 1'b1;
         return;
      end
      s = flt_mem[p[7:0]];
      if (s == c) begin
         flt_ptr = 9'(p + 1);
      end else if (s == CHAR_PLUS) begin
         if (!level_head(p) || !(p + 1 == flt_len || stored_is(p + 1, CHAR_SLASH))) begin
            miss = 1'b1;
            return;
         end
         p++;
         if (c == CHAR_SLASH) begin
            if (p >= flt_len) begin
               miss = 1'b1;
               return;
            end
            p++;
         end else begin
            scan_mode = MODE_SKIP_LEVEL;
         end
         flt_ptr = 9'(p);
      end else if (s == CHAR_HASH) begin
         if (!level_head(p) || p + 1 != flt_len) miss = 1'b1;
         else scan_mode = MODE_SKIP_REST;
      end else begin
         miss = 1'b1;
      end
   endfunction

   function automatic bit topic_matches();
      int         p;
      int         n;
      logic [7:0] s;
      p = int'(flt_ptr);
      n = int'(flt_len);
      if (miss) return 1'b0;
      if (scan_mode == MODE_SKIP_REST) return 1'b1;
      if (p >= n) return 1'b1;
      s = flt_mem[p[7:0]];
      if (s == CHAR_PLUS) begin
         if (!level_head(p)) return 1'b0;
         if (p + 1 == n) return 1'b1;
         return stored_is(p + 1, CHAR_SLASH) && stored_is(p + 2, CHAR_HASH) && p + 3 == n;
      end
      if (s == CHAR_HASH) return level_head(p) && p + 1 == n;
      if (s == CHAR_SLASH) return stored_is(p + 1, CHAR_HASH) && p + 2 == n;
      return 1'b0;
   endfunction

   // advances the model by one request word; returns 1 when a verdict is due
   function automatic bit predict_verdict(input logic kind, input logic [7:0] c,
                                          input logic last, output result_type res);
      bit new_flt;
      res = '0;
      if (kind == REQ_FILTER) begin
         new_flt = flt_done;
         if (new_flt) begin
            flt_len  = '0;
            ovf      = 1'b0;
            flt_done = 1'b0;
         end
         topic_head = 1'b1;
         scan_mode  = MODE_LITERAL;
         miss       = 1'b0;
         flt_ptr    = '0;
         if (!(new_flt && last && c == CHAR_NUL)) begin
            if (flt_len < MAX_BYTES) begin
               flt_mem[flt_len[7:0]] = c;
               flt_len++;
            end else begin
               ovf = 1'b1;
            end
         end
         if (last) flt_done = 1'b1;
         return 1'b0;
      end
      flt_done = 1'b1;
      if (topic_head) begin
         topic_head = 1'b0;
         flt_ptr    = '0;
         scan_mode  = MODE_LITERAL;
         miss       = 1'b0;
         if (c == CHAR_NUL && last) miss = 1'b1;
         else if (flt_len == 0) miss = 1'b1;
         else if ((flt_mem[0] == CHAR_DOLLAR) != (c == CHAR_DOLLAR)) miss = 1'b1;
      end
      if (!miss) begin
         if (c == CHAR_PLUS || c == CHAR_HASH) begin
            miss = 1'b1;
         end else if (scan_mode == MODE_LITERAL) begin
            scan_literal(c);
         end else if (scan_mode == MODE_SKIP_LEVEL && c == CHAR_SLASH) begin
            scan_mode = MODE_LITERAL;
            scan_literal(c);
         end
      end
      if (!last) return 1'b0;
      res.matched         = topic_matches();
      res.filter_overflow = ovf;
      topic_head          = 1'b1;
      return 1'b1;
   endfunction

   // checks verdicts first, then books the verdict of a newly accepted word
   always @(posedge clock) begin
      result_type got;
      result_type want;
      result_type pred;
      if (reset) begin
         flt_len    = '0;
         flt_ptr    = '0;
         flt_done   = 1'b1;
         scan_mode  = MODE_LITERAL;
         miss       = 1'b0;
         topic_head = 1'b1;
         ovf        = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.matched         = rsp_matched;
            got.filter_overflow = rsp_filter_overflow;
            if (verdicts_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, got matched %0b overflow %0b",
                        $time, got.matched, got.filter_overflow);
            end else begin
               want = verdicts_due.pop_front();
               verdicts_checked++;
               if (want.filter_overflow) overflow_verdicts++;
               if (got.matched !== want.matched) begin
                  errors++;
                  $display("%0t: matched expected %0b got %0b",
                           $time, want.matched, got.matched);
               end
               if (got.filter_overflow !== want.filter_overflow) begin
                  errors++;
                  $display("%0t: filter_overflow expected %0b got %0b",
                           $time, want.filter_overflow, got.filter_overflow);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (predict_verdict(req_req_type, req_data_byte, req_last, pred)) begin
               if (pin_on) begin
                  pred.matched         = pin_matched;
                  pred.filter_overflow = pin_overflow;
               end
               verdicts_due.push_back(pred);
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_word(input logic kind, input logic [7:0] data, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_req_type  <= kind;
      req_data_byte <= data;
      req_last      <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      words_sent++;
   endtask

   // an empty closed string goes out as a lone zero word
   task automatic send_bytes(input logic kind, input bytes_type s, input bit close);
      if (s.size() == 0) begin
         if (close) send_word(kind, CHAR_NUL, 1'b1);
      end else begin
         foreach (s[i]) send_word(kind, s[i], close && i == s.size() - 1);
      end
   endtask

   task automatic rand_text(output bytes_type s, input int maxlen);
      s = {};
      repeat ($urandom_range(0, maxlen)) s.push_back(8'(8'h61 + $urandom_range(0, 2)));
   endtask

   task automatic append(inout bytes_type q, input bytes_type s);
      foreach (s[i]) q.push_back(s[i]);
   endtask

   task automatic rand_noise(output bytes_type s);
      logic [7:0] picks [5];
      picks = '{CHAR_SLASH, CHAR_PLUS, CHAR_HASH, CHAR_DOLLAR, 8'h61};
      s = {};
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(0, 3) == 0) s.push_back(picks[3'($urandom_range(0, 4))]);
         else s.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // filter built level by level, with a topic that mostly fits it
   task automatic make_pair(output bytes_type flt, output bytes_type top);
      bytes_type lv;
      bytes_type lv2;
      int        nlev;
      int        pick;
      flt  = {};
      top  = {};
      nlev = $urandom_range(1, 4);
      for (int i = 0; i < nlev; i++) begin
         if (i > 0) begin
            flt.push_back(CHAR_SLASH);
            top.push_back(CHAR_SLASH);
         end
         pick = $urandom_range(0, 9);
         rand_text(lv, 2);
         if (pick <= 5) begin
            append(flt, lv);
            append(top, lv);
         end else if (pick <= 7) begin
            flt.push_back(CHAR_PLUS);
            append(top, lv);
         end else if (pick == 8) begin
            flt.push_back(CHAR_HASH);
            case ($urandom_range(0, 2))
               0: begin
                  if (i > 0) void'(top.pop_back());
               end
               1: append(top, lv);
               default: begin
                  append(top, lv);
                  top.push_back(CHAR_SLASH);
                  rand_text(lv2, 2);
                  append(top, lv2);
               end
            endcase
            if ($urandom_range(0, 1) == 1) break;
         end else begin
            // wildcard glued to text
            rand_text(lv2, 1);
            if ($urandom_range(0, 1) == 1) lv2.push_back(CHAR_PLUS);
            else lv2.push_front(CHAR_HASH);
            append(flt, lv2);
            append(top, lv);
         end
      end
      if ($urandom_range(0, 7) == 0) begin
         flt.push_front(CHAR_DOLLAR);
         if ($urandom_range(0, 3) != 0) top.push_front(CHAR_DOLLAR);
      end
      if ($urandom_range(0, 9) == 0 && top.size() > 0)
         top[$urandom_range(0, top.size() - 1)] = 8'(8'h61 + $urandom_range(0, 3));
   endtask

   task automatic run_sequence(input bit force_long);
      bytes_type flt;
      bytes_type top;
      bytes_type alt;
      int        pick;
      int        n;
      pick = force_long ? 95 : $urandom_range(0, 99);
      if (pick < 70) begin
         make_pair(flt, top);
         send_bytes(REQ_FILTER, flt, 1'b1);
         send_bytes(REQ_TOPIC, top, 1'b1);
         if ($urandom_range(0, 9) < 4) begin
            alt = top;
            if ($urandom_range(0, 1) == 1) begin
               alt.push_back(CHAR_SLASH);
               alt.push_back(8'h61);
            end else if (alt.size() > 1) begin
               void'(alt.pop_back());
            end
            send_bytes(REQ_TOPIC, alt, 1'b1);
         end
      end else if (pick < 80) begin
         rand_noise(top);
         send_bytes(REQ_TOPIC, top, 1'b1);
      end else if (pick < 88) begin
         rand_noise(flt);
         send_bytes(REQ_FILTER, flt, 1'b1);
      end else if (pick < 94) begin
         make_pair(flt, top);
         if ($urandom_range(0, 1) == 1) begin
            // filter cut short by a topic
            send_bytes(REQ_FILTER, flt, 1'b0);
            send_bytes(REQ_TOPIC, top, 1'b1);
         end else begin
            // topic dropped by a new filter
            send_bytes(REQ_TOPIC, top, 1'b0);
            send_bytes(REQ_FILTER, flt, 1'b1);
            send_bytes(REQ_TOPIC, top, 1'b1);
         end
      end else if (pick < 96) begin
         // filter near or past the store size
         flt = {};
         n   = $urandom_range(250, 262);
         repeat (n) flt.push_back(($urandom_range(0, 9) == 0) ? CHAR_SLASH : 8'h61);
         top = flt;
         while (top.size() > MAX_BYTES) void'(top.pop_back());
         send_bytes(REQ_FILTER, flt, 1'b1);
         send_bytes(REQ_TOPIC, top, 1'b1);
      end else begin
         flt = {};
         send_bytes(($urandom_range(0, 1) == 1) ? REQ_TOPIC : REQ_FILTER, flt, 1'b1);
      end
   endtask

   initial begin
      int start_words;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_req_type  = REQ_FILTER;
      req_data_byte = CHAR_NUL;
      req_last      = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      words_sent    = 0;
      pin_on        = 1'b0;
      pin_matched   = 1'b0;
      pin_overflow  = 1'b0;

      dir_rows = '{
         // filter a/#, parent level matches
         '{REQ_FILTER, "a",         1'b0, 1'b0, 1'b0, 1'b0},
         '{REQ_FILTER, CHAR_SLASH,  1'b0, 1'b0, 1'b0, 1'b0},
         '{REQ_FILTER, CHAR_HASH,   1'b1, 1'b0, 1'b0, 1'b0},
         '{REQ_TOPIC,  "a",         1'b1, 1'b1, 1'b1, 1'b0},
         // wildcard in topic, empty topic
         '{REQ_TOPIC,  CHAR_PLUS,   1'b1, 1'b1, 1'b0, 1'b0},
         '{REQ_TOPIC,  CHAR_NUL,    1'b1, 1'b1, 1'b0, 1'b0},
         // filter +, dollar on topic only, then lone separator
         '{REQ_FILTER, CHAR_PLUS,   1'b1, 1'b0, 1'b0, 1'b0},
         '{REQ_TOPIC,  CHAR_DOLLAR, 1'b0, 1'b0, 1'b0, 1'b0},
         '{REQ_TOPIC,  "s",         1'b1, 1'b1, 1'b0, 1'b0},
         '{REQ_TOPIC,  CHAR_SLASH,  1'b1, 1'b0, 1'b0, 1'b0},
         // hash not last
         '{REQ_FILTER, CHAR_HASH,   1'b0, 1'b0, 1'b0, 1'b0},
         '{REQ_FILTER, CHAR_SLASH,  1'b0, 1'b0, 1'b0, 1'b0},
         '{REQ_FILTER, "a",         1'b1, 1'b0, 1'b0, 1'b0},
         '{REQ_TOPIC,  "x",         1'b0, 1'b0, 1'b0, 1'b0},
         '{REQ_TOPIC,  CHAR_SLASH,  1'b0, 1'b0, 1'b0, 1'b0},
         '{REQ_TOPIC,  "a",         1'b1, 1'b1, 1'b0, 1'b0},
         // empty filter
         '{REQ_FILTER, CHAR_NUL,    1'b1, 1'b0, 1'b0, 1'b0},
         '{REQ_TOPIC,  "q",         1'b1, 1'b1, 1'b0, 1'b0},
         // topic ends filter load
         '{REQ_FILTER, "a",         1'b0, 1'b0, 1'b0, 1'b0},
         '{REQ_TOPIC,  "a",         1'b1, 1'b0, 1'b0, 1'b0},
         '{REQ_TOPIC,  8'hFF,       1'b1, 1'b0, 1'b0, 1'b0},
         // filter word drops a topic in progress
         '{REQ_FILTER, "z",         1'b1, 1'b0, 1'b0, 1'b0},
         '{REQ_TOPIC,  "z",         1'b0, 1'b0, 1'b0, 1'b0},
         '{REQ_FILTER, "k",         1'b1, 1'b0, 1'b0, 1'b0},
         '{REQ_TOPIC,  "k",         1'b1, 1'b0, 1'b0, 1'b0}
      };

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         pin_on       = dir_rows[i].pinned;
         pin_matched  = dir_rows[i].pin_matched;
         pin_overflow = dir_rows[i].pin_overflow;
         send_word(dir_rows[i].kind, dir_rows[i].data, dir_rows[i].last);
      end
      pin_on = 1'b0;

      start_words = words_sent;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 53; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 53; end
            default: begin send_idle_pct = 33; rsp_stall_pct = 33; end
         endcase
         if (ph == 0) run_sequence(1'b1);
         while (words_sent - start_words < (ph + 1) * RANDOM_WORDS / 4) run_sequence(1'b0);
      end
      req_valid <= 1'b0;

      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d request words and checked %0d verdicts (%0d with filter cut)",
               words_sent, verdicts_checked, overflow_verdicts);
      $display("idle patterns: none, sender gaps, receiver stalls, both; %0d mismatches",
               errors);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/tfm_pkg.sv
rtl/tfm_ram.sv
rtl/tfm_match.sv
rtl/tfm_out_buf.sv
rtl/topic_filter_matcher_core.sv
bench/testbench.sv
